### hw/rtl/swse_pkg.sv
// Package with the sizes, register codes and types of the sliding-window slope estimator.
`default_nettype none

package swse_pkg;

  // Ring depth and sample width.
  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 16;

  // Fixed register widths.
  localparam int WLEN_W = 7;
  localparam int RATE_W = 16;
  localparam int SLOPE_W = 32;

  // Derived widths.
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int NW     = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (NW > WLEN_W) ? NW : WLEN_W;
  localparam int S_W    = SAMPLE_BITS + PTR_W + 1;
  localparam int WSUM_W = SAMPLE_BITS + 2 * PTR_W + 2;
  localparam int NUM_W  = WSUM_W + 2;
  localparam int D_W    = 3 * PTR_W;
  localparam int SCALE  = 6 * 256;
  localparam int SCALE_W = $clog2(SCALE + 1);
  localparam int B_W    = RATE_W + SCALE_W;
  localparam int P_W    = NUM_W + B_W;
  localparam int DIV_W  = 2 * ((P_W + 2) / 2);
  localparam int DIV_ITER = DIV_W / 2;
  localparam int CNT_W  = $clog2(DIV_ITER);

  // APB register map.
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0,
    REG_SAMPLE_RATE   = 1'b1
  } reg_idx_e;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(16);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(600);

endpackage

`default_nettype wire

### hw/rtl/sliding_window_slope_estimator.sv
// Top level of the sliding-window least-squares slope estimator.
// Steps after the edge that accepts a sample beat: sum update, numerator, one multiply,
//   an iterative radix-4 restoring divider, and the output load that raises slope_valid_o.
// No new sample is taken until the previous result is in the output register.
// Reset: asynchronous and active low; sums, write position and ring valid bits clear,
//   window_length returns to 16 and sample_rate to 600. No clearing pass is needed.
`default_nettype none

module sliding_window_slope_estimator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Sample channel.
  input  wire logic                             sample_valid_i,
  output logic                                  sample_ready_o,
  input  wire logic signed [swse_pkg::SAMPLE_BITS-1:0] sample_i,
  // Slope channel.
  output logic                                  slope_valid_o,
  input  wire logic                             slope_ready_i,
  output logic signed [swse_pkg::SLOPE_W-1:0]   slope_o,
  // APB configuration port.
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [swse_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [swse_pkg::DATA_W-1:0]      pwdata,
  output logic [swse_pkg::DATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int SB      = swse_pkg::SAMPLE_BITS;
  localparam int PTR_W   = swse_pkg::PTR_W;
  localparam int NW      = swse_pkg::NW;
  localparam int CMP_W   = swse_pkg::CMP_W;
  localparam int S_W     = swse_pkg::S_W;
  localparam int WSUM_W  = swse_pkg::WSUM_W;
  localparam int NUM_W   = swse_pkg::NUM_W;
  localparam int D_W     = swse_pkg::D_W;
  localparam int B_W     = swse_pkg::B_W;
  localparam int P_W     = swse_pkg::P_W;
  localparam int DIV_W   = swse_pkg::DIV_W;
  localparam int CNT_W   = swse_pkg::CNT_W;
  localparam int OW      = swse_pkg::SLOPE_W;
  localparam int MAXW    = swse_pkg::MAX_WINDOW;
  localparam int KY_W    = NW + 1 + SB;
  localparam int KS_W    = NW + 1 + S_W;

  localparam logic [NW-1:0]    N_MIN = NW'(2);
  localparam logic [NW-1:0]    N_MAX = NW'(MAXW);
  localparam logic [PTR_W:0]   RING_DEPTH = (PTR_W + 1)'(MAXW);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAXW - 1);
  localparam logic [B_W-1:0]   SCALE_C = B_W'(swse_pkg::SCALE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(swse_pkg::DIV_ITER - 1);
  localparam logic [OW-1:0]    LIM_POS = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0]    LIM_NEG = {1'b1, {(OW-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_NUM,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  // Registers.
  state_e                      state_q;
  logic [swse_pkg::WLEN_W-1:0] wl_q;
  logic [swse_pkg::RATE_W-1:0] rate_q;
  logic [PTR_W-1:0]            wp_q;
  logic signed [S_W-1:0]       ssum_q;
  logic signed [WSUM_W-1:0]    wsum_q;
  logic [MAXW-1:0]             valid_q;
  logic signed [SB-1:0]        y_q;
  logic [NW-1:0]               n_q;
  logic                        old_vld_q;
  logic signed [SB-1:0]        mem_rd_q;
  logic [2*NW-1:0]             nsq_q;
  logic [D_W-1:0]              d_q;
  logic [B_W-1:0]              b_q;
  logic [NUM_W-1:0]            mag_q;
  logic                        neg_q;
  logic [DIV_W-1:0]            div_q;
  logic [D_W-1:0]              rem_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [OW-1:0]               slope_q;
  logic                        out_vld_q;

  // The sample ring is a single-port-write, registered-read memory.
  logic signed [SB-1:0]        ring_mem [MAXW];

  // Combinational signals.
  logic                        cfg_we;
  logic                        in_acc;
  logic                        out_acc;
  logic                        ring_we;
  logic [CMP_W-1:0]            wl_ext;
  logic [NW-1:0]               n_clamp;
  logic [PTR_W:0]              slot_sum;
  logic [PTR_W-1:0]            slot;
  logic [PTR_W-1:0]            wp_inc;
  logic [NW-1:0]               nm1;
  logic signed [S_W-1:0]       old_ext;
  logic signed [S_W-1:0]       rest;
  logic signed [KY_W-1:0]      ky;
  logic signed [WSUM_W-1:0]    wsum_d;
  logic signed [S_W-1:0]       ssum_d;
  logic signed [KS_W-1:0]      ks;
  logic signed [NUM_W-1:0]     num;
  logic [NUM_W-1:0]            mag_d;
  logic [3*NW-1:0]             d_full;
  logic [B_W-1:0]              b_d;
  logic [P_W-1:0]              prod;
  logic [D_W:0]                t1;
  logic [D_W:0]                t2;
  logic                        qb1;
  logic                        qb2;
  logic [D_W-1:0]              r1;
  logic [D_W-1:0]              r2;
  logic [OW-1:0]               lim;
  logic [OW-1:0]               sat;
  logic [OW-1:0]               res;

  assign cfg_we  = psel & penable & pwrite;
  assign in_acc  = sample_valid_i & sample_ready_o;
  assign out_acc = out_vld_q & slope_ready_i;
  assign ring_we = (state_q == S_READ);

  assign sample_ready_o = (state_q == S_IDLE);
  assign slope_valid_o  = out_vld_q;
  assign slope_o        = slope_q;
  assign pready         = 1'b1;

  // Register readback.
  always_comb begin
    case (paddr[2])
      swse_pkg::REG_WINDOW_LENGTH: prdata = swse_pkg::DATA_W'(wl_q);
      swse_pkg::REG_SAMPLE_RATE:   prdata = swse_pkg::DATA_W'(rate_q);
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    // Window length is clamped to the range the ring supports.
    wl_ext = CMP_W'(wl_q);
    if (wl_ext < CMP_W'(N_MIN)) begin
      n_clamp = N_MIN;
    end else if (wl_ext > CMP_W'(N_MAX)) begin
      n_clamp = N_MAX;
    end else begin
      n_clamp = wl_ext[NW-1:0];
    end

    // The oldest sample of the window sits n slots behind the write position.
    slot_sum = (PTR_W + 1)'(wp_q) + RING_DEPTH - (PTR_W + 1)'(n_clamp);
    if (slot_sum >= RING_DEPTH) begin
      slot = PTR_W'(slot_sum - RING_DEPTH);
    end else begin
      slot = slot_sum[PTR_W-1:0];
    end
    wp_inc = (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;

    // Running-sum update: the oldest sample leaves, every other sample moves
    // one place older, and the new sample enters at weight n-1.
    nm1     = n_q - 1'b1;
    old_ext = old_vld_q ? {{(S_W-SB){mem_rd_q[SB-1]}}, mem_rd_q} : '0;
    rest    = ssum_q - old_ext;
    ky      = $signed({1'b0, nm1}) * y_q;
    wsum_d  = wsum_q - {{(WSUM_W-S_W){rest[S_W-1]}}, rest}
              + {{(WSUM_W-KY_W){ky[KY_W-1]}}, ky};
    ssum_d  = rest + {{(S_W-SB){y_q[SB-1]}}, y_q};

    // Numerator 2W - (n-1)S and its magnitude.
    ks    = $signed({1'b0, nm1}) * ssum_q;
    num   = {wsum_q[WSUM_W-1], wsum_q, 1'b0} - {{(NUM_W-KS_W){ks[KS_W-1]}}, ks};
    mag_d = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    d_full = n_q * (nsq_q - 1'b1);
    b_d    = B_W'(rate_q) * SCALE_C;
    prod   = P_W'(mag_q) * P_W'(b_q);

    // Two restoring division steps per cycle.
    t1  = {rem_q, div_q[DIV_W-1]};
    qb1 = (t1 >= {1'b0, d_q});
    r1  = qb1 ? D_W'(t1 - {1'b0, d_q}) : t1[D_W-1:0];
    t2  = {r1, div_q[DIV_W-2]};
    qb2 = (t2 >= {1'b0, d_q});
    r2  = qb2 ? D_W'(t2 - {1'b0, d_q}) : t2[D_W-1:0];

    // Saturate the quotient and apply the sign.
    lim = neg_q ? LIM_NEG : LIM_POS;
    sat = (div_q > DIV_W'(lim)) ? lim : div_q[OW-1:0];
    res = neg_q ? (~sat + 1'b1) : sat;
  end

  // Ring memory: written in the update cycle, with a registered read of the addressed slot.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[wp_q] <= y_q;
    end
    mem_rd_q <= ring_mem[slot];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wl_q      <= swse_pkg::WLEN_RESET;
      rate_q    <= swse_pkg::RATE_RESET;
      wp_q      <= '0;
      ssum_q    <= '0;
      wsum_q    <= '0;
      valid_q   <= '0;
      old_vld_q <= 1'b0;
      y_q       <= '0;
      n_q       <= N_MIN;
      nsq_q     <= '0;
      d_q       <= '0;
      b_q       <= '0;
      mag_q     <= '0;
      neg_q     <= 1'b0;
      div_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      slope_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      old_vld_q <= valid_q[slot];
      // In the done state a taken beat is always replaced by the new result below.
      if (out_acc && (state_q != S_DONE)) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            y_q     <= sample_i;
            n_q     <= n_clamp;
            state_q <= S_READ;
          end
        end
        S_READ: begin
          wsum_q        <= wsum_d;
          ssum_q        <= ssum_d;
          valid_q[wp_q] <= 1'b1;
          wp_q          <= wp_inc;
          nsq_q         <= n_q * n_q;
          state_q       <= S_NUM;
        end
        S_NUM: begin
          mag_q   <= mag_d;
          neg_q   <= num[NUM_W-1];
          d_q     <= d_full[D_W-1:0];
          b_q     <= b_d;
          state_q <= S_MUL;
        end
        S_MUL: begin
          div_q   <= DIV_W'(prod);
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          div_q <= {div_q[DIV_W-3:0], qb1, qb2};
          rem_q <= r2;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_vld_q || slope_ready_i) begin
            slope_q   <= res;
            out_vld_q <= 1'b1;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // A register write clears the window so the fit restarts from zeros.
      if (cfg_we) begin
        case (paddr[2])
          swse_pkg::REG_WINDOW_LENGTH: wl_q <= pwdata[swse_pkg::WLEN_W-1:0];
          swse_pkg::REG_SAMPLE_RATE:   rate_q <= pwdata[swse_pkg::RATE_W-1:0];
          default: ;
        endcase
        wp_q    <= '0;
        ssum_q  <= '0;
        wsum_q  <= '0;
        valid_q <= '0;
      end
    end
  end

`ifndef SYNTH
  // An accepted sample always starts with the ring read cycle.
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_READ)
    else $error("accepted sample did not enter the read cycle");

  // The divisor is never zero while the divider runs.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> d_q != '0)
    else $error("zero divisor in divider");

  // Each update advances the write position by exactly one slot.
  a_wp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) && !cfg_we |=> wp_q == $past(wp_inc))
    else $error("write position did not advance");

  // A finished result with a free output register is delivered at once.
  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && !out_vld_q |=> out_vld_q && (state_q == S_IDLE))
    else $error("finished result was not loaded");
`endif

endmodule

`default_nettype wire

### sim/sliding_window_slope_estimator_test.sv
// Self-checking testbench for the sliding-window least-squares slope estimator.
module sliding_window_slope_estimator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS = swse_pkg::SAMPLE_BITS;
  localparam int SLOPE_W     = swse_pkg::SLOPE_W;
  localparam int MAX_WINDOW  = swse_pkg::MAX_WINDOW;
  localparam int WLEN_W      = swse_pkg::WLEN_W;
  localparam int RATE_W      = swse_pkg::RATE_W;
  localparam int ADDR_W      = swse_pkg::ADDR_W;
  localparam int DATA_W      = swse_pkg::DATA_W;

  // A run fails if this many cycles pass with no sample beat, no slope beat and
  // no register access. The slowest legal stretch is a full computation followed
  // by a receiver that idles in 83 percent of cycles.
  localparam int STALL_LIMIT = 20000;
  // Quiet time after the last expected slope, so that a stray extra beat is caught.
  localparam int TAIL_CYCLES = 100;

  // Shapes of the random sample runs. Ramps and flats give clean, known slopes
  // and make up most of the stream; noise and full-scale swings fill in the rest.
  typedef enum int {
    SHAPE_RAMP,
    SHAPE_FLAT,
    SHAPE_NOISE,
    SHAPE_SWING
  } run_shape_e;

  // DUT ports. Every input has a known value from time zero.
  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          sample_valid_i = 1'b0;
  logic                          sample_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_i       = '0;
  logic                          slope_valid_o;
  logic                          slope_ready_i  = 1'b0;
  logic signed [SLOPE_W-1:0]     slope_o;
  logic                          psel           = 1'b0;
  logic                          penable        = 1'b0;
  logic                          pwrite         = 1'b0;
  logic [ADDR_W-1:0]             paddr          = '0;
  logic [DATA_W-1:0]             pwdata         = '0;
  logic [DATA_W-1:0]             prdata;
  logic                          pready;

  sliding_window_slope_estimator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .sample_i       (sample_i),
    .slope_valid_o  (slope_valid_o),
    .slope_ready_i  (slope_ready_i),
    .slope_o        (slope_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Samples waiting to be driven, and slopes the block owes us, oldest first.
  logic signed [SAMPLE_BITS-1:0] sample_backlog[$];
  logic signed [SLOPE_W-1:0]     slope_expected[$];

  // Mirror of the block's registers and of its window state. The sums are kept
  // wide so that they never wrap, whatever the window or the samples.
  logic [WLEN_W-1:0] cfg_window = swse_pkg::WLEN_RESET;
  logic [RATE_W-1:0] cfg_rate   = swse_pkg::RATE_RESET;
  longint            hist_samples[MAX_WINDOW];
  int                hist_pos;
  longint            sum_y;
  longint            sum_ky;

  // Percentage of cycles in which each side holds off.
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 83;

  // Set by the monitor at each rising edge, read by the driver at the falling edge.
  bit sample_fire;

  int errors;
  int samples_taken;
  int slopes_seen;
  int reg_writes;
  int clipped_slopes;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Prints one line per mismatch and counts them all.
  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    errors++;
  endtask

  // Empties the sample history, as the block does on reset or on any register write.
  function automatic void clear_history();
    foreach (hist_samples[i]) hist_samples[i] = 0;
    hist_pos = 0;
    sum_y    = 0;
    sum_ky   = 0;
  endfunction

  // Pushes one sample into the history and returns the least-squares slope of the
  // newest N samples. With x = 0 for the oldest sample, sliding the window by one
  // takes every old sample down one step of x, so the weighted sum loses the sum of
  // the survivors and gains (N-1) times the new sample. The slope is
  // 6*(2*Wsum - (N-1)*Ysum) * rate * 256 / (N*(N*N-1)), truncated toward zero and
  // clipped to 32 bits. The product stays below 2^56, so plain 64-bit math is exact.
  function automatic logic signed [SLOPE_W-1:0] next_fit_slope(
      input logic signed [SAMPLE_BITS-1:0] y);
    int unsigned       n;
    int unsigned       oldest_slot;
    longint            survivors;
    longint            numer;
    longint unsigned   mag;
    longint unsigned   denom;
    longint unsigned   scale;
    longint unsigned   quot;
    longint unsigned   clip;
    bit                neg;
    n = cfg_window;
    if (n < 2) n = 2;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    oldest_slot = (hist_pos + MAX_WINDOW - n) % MAX_WINDOW;
    survivors   = sum_y - hist_samples[oldest_slot];
    sum_ky      = sum_ky - survivors + longint'(n - 1) * longint'(y);
    sum_y       = survivors + longint'(y);
    hist_samples[hist_pos] = longint'(y);
    hist_pos    = (hist_pos + 1) % MAX_WINDOW;

    numer = 2 * sum_ky - longint'(n - 1) * sum_y;
    neg   = numer < 0;
    mag   = neg ? longint'(-numer) : longint'(numer);
    denom = longint'(n) * (longint'(n) * longint'(n) - 1);
    scale = 64'd1536 * longint'(cfg_rate);
    quot  = (mag * scale) / denom;
    clip  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (quot > clip) begin
      quot = clip;
      clipped_slopes++;
    end
    return SLOPE_W'(neg ? (64'd0 - quot) : quot);
  endfunction

  // One APB transfer: a setup cycle, then an access cycle that completes on pready.
  task automatic apb_transfer(input logic is_write, input swse_pkg::reg_idx_e idx,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= ADDR_W'(4 * int'(idx));
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Writes a register with random junk above its width, updates the mirror, and
  // reads the register back. Any write wipes the window history.
  task automatic write_register(input swse_pkg::reg_idx_e idx, input int unsigned value);
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] want;
    if (idx == swse_pkg::REG_WINDOW_LENGTH) begin
      cfg_window = WLEN_W'(value);
      wdata = {$urandom()} << WLEN_W | DATA_W'(cfg_window);
      want  = DATA_W'(cfg_window);
    end else begin
      cfg_rate = RATE_W'(value);
      wdata = {$urandom()} << RATE_W | DATA_W'(cfg_rate);
      want  = DATA_W'(cfg_rate);
    end
    apb_transfer(1'b1, idx, wdata, rdata);
    clear_history();
    reg_writes++;
    apb_transfer(1'b0, idx, '0, rdata);
    if (rdata !== want)
      report_mismatch($sformatf("register %s read back 0x%0h, expected 0x%0h",
                                idx.name(), rdata, want));
  endtask

  // Blocks until every queued sample has gone in and every owed slope has come out.
  task automatic wait_for_drain();
    while (sample_backlog.size() != 0 || sample_valid_i || slope_expected.size() != 0)
      @(posedge clk_i);
  endtask

  // Queues random runs of samples, mostly ramps and flats, some noise and swings.
  task automatic queue_sample_runs(input int count);
    int         left;
    int         run_len;
    int         pick;
    longint     base;
    longint     step;
    longint     v;
    bit         swing_high;
    run_shape_e shape;
    left = count;
    while (left > 0) begin
      run_len = $urandom_range(40, 4);
      if (run_len > left) run_len = left;
      pick = $urandom_range(9);
      if (pick < 5)      shape = SHAPE_RAMP;
      else if (pick < 7) shape = SHAPE_FLAT;
      else if (pick < 9) shape = SHAPE_NOISE;
      else               shape = SHAPE_SWING;
      base       = longint'($urandom_range(65535)) - 32768;
      step       = longint'($urandom_range(4000)) - 2000;
      swing_high = $urandom_range(1);
      for (int k = 0; k < run_len; k++) begin
        case (shape)
          SHAPE_RAMP:  v = base + step * k;
          SHAPE_FLAT:  v = base;
          SHAPE_NOISE: v = longint'($urandom_range(65535)) - 32768;
          default: begin
            v = swing_high ? 32767 : -32768;
            swing_high = !swing_high;
          end
        endcase
        // Ramps that run off the end of the range flatten into a plateau.
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        sample_backlog.push_back(SAMPLE_BITS'(v));
      end
      left -= run_len;
    end
  endtask

  // Sample driver. A new beat may go out once the slot is free, i.e. nothing is on
  // the wire or the beat on the wire was taken at the last rising edge.
  always @(negedge clk_i) begin
    if (!sample_valid_i || sample_fire) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_valid_i <= 1'b1;
        sample_i       <= sample_backlog.pop_front();
      end else begin
        sample_valid_i <= 1'b0;
      end
    end
  end

  // Slope receiver back-pressure.
  always @(negedge clk_i) begin
    slope_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predicts on each accepted sample beat and checks each slope beat
  // against the oldest prediction.
  always @(posedge clk_i) begin
    logic signed [SLOPE_W-1:0] want;
    sample_fire = sample_valid_i && sample_ready_o;
    if (sample_fire) begin
      slope_expected.push_back(next_fit_slope(sample_i));
      samples_taken++;
    end
    if (slope_valid_o && slope_ready_i) begin
      slopes_seen++;
      if (slope_expected.size() == 0) begin
        report_mismatch($sformatf("slope beat %0d (%0d) arrived with no sample owed",
                                  slopes_seen, slope_o));
      end else begin
        want = slope_expected.pop_front();
        if (slope_o !== want)
          report_mismatch($sformatf("slope beat %0d: slope %0d, expected %0d",
                                    slopes_seen, slope_o, want));
      end
    end
  end

  // Watchdog: counts cycles with no traffic of any kind.
  always @(posedge clk_i) begin
    int quiet_cycles;
    if ((sample_valid_i && sample_ready_o) || (slope_valid_o && slope_ready_i) ||
        (psel && penable && pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: %0d cycles without any beat, %0d slopes still owed",
                 quiet_cycles, slope_expected.size());
        $display("sliding_window_slope_estimator: mismatch");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned seg_window;
    int unsigned seg_rate;
    clear_history();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, first with the reset settings (window 16, 600 samples/s):
    // full-scale steps, zero and the values next to it.
    sample_backlog = '{32767, -32768, 0, -1, 1, 32767};
    wait_for_drain();

    // Window below the minimum acts as two samples; at the top rate a full-scale
    // step clips the slope at both ends of the 32-bit range.
    write_register(swse_pkg::REG_WINDOW_LENGTH, 1);
    write_register(swse_pkg::REG_SAMPLE_RATE, 65535);
    sample_backlog = '{-32768, 32767, -32768, 0, 32767};
    wait_for_drain();

    // Window above the maximum acts as the full ring; zero rate gives zero slope.
    write_register(swse_pkg::REG_WINDOW_LENGTH, 127);
    write_register(swse_pkg::REG_SAMPLE_RATE, 0);
    sample_backlog = '{32767, -32768, 12345};
    wait_for_drain();

    // Full ring at the lowest nonzero rate.
    write_register(swse_pkg::REG_WINDOW_LENGTH, 64);
    write_register(swse_pkg::REG_SAMPLE_RATE, 1);
    sample_backlog = '{-32768, -32768, 32767, -1};
    wait_for_drain();

    // Random part: nine segments, each under its own settings. The first three run
    // with a slow receiver, the next three with a slow sender, the last three with
    // no idling at all. Halfway through each segment the sender holds back until
    // every owed slope has come out, then carries on with the same history.
    for (int seg = 0; seg < 9; seg++) begin
      case (seg)
        0: begin seg_window = 2;                      seg_rate = 65535; end
        1: begin seg_window = 64;                     seg_rate = 1; end
        2: begin seg_window = 0;                      seg_rate = $urandom_range(65535, 1); end
        3: begin seg_window = 127;                    seg_rate = 65535; end
        4: begin seg_window = 16;                     seg_rate = 600; end
        5: begin seg_window = $urandom_range(64, 2);  seg_rate = 0; end
        6: begin seg_window = 1;                      seg_rate = $urandom_range(65535, 1); end
        7: begin seg_window = 3;                      seg_rate = $urandom_range(65535, 1); end
        default: begin
          seg_window = $urandom_range(64, 2);
          seg_rate   = $urandom_range(65535, 1);
        end
      endcase
      if (seg < 3) begin
        send_idle_pct = 28;
        recv_idle_pct = 83;
      end else if (seg < 6) begin
        send_idle_pct = 83;
        recv_idle_pct = 28;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_register(swse_pkg::REG_WINDOW_LENGTH, seg_window);
      write_register(swse_pkg::REG_SAMPLE_RATE, seg_rate);
      queue_sample_runs(80);
      wait_for_drain();
      queue_sample_runs(80);
      wait_for_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Covered %0d sample beats and %0d slope beats across %0d register writes,",
             samples_taken, slopes_seen, reg_writes);
    $display("windows from 2 to 64 and rates from 0 to 65535; %0d slopes clipped.",
             clipped_slopes);
    if (errors == 0) begin
      $display("sliding_window_slope_estimator: match");
    end else begin
      $display("%0d mismatches found", errors);
      $display("sliding_window_slope_estimator: mismatch");
    end
    $finish;
  end

endmodule
